/* sv/itoa_pkg.sv */
// shared constants, types and helpers for the radix integer-to-ascii converter
package itoa_pkg;

  localparam int VALUE_BITS = 64;
  localparam int MAX_DIGITS = 64;

  localparam int IN_VALUE_W = 64;
  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 7;
  localparam int DIGIT_W    = 6;

  // quotient bits produced per division cycle
  localparam int STEP_BITS = 8;
  localparam int CHUNKS    = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int QUOT_W    = CHUNKS * STEP_BITS;
  localparam int CHUNK_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  localparam int DIGIT_AW = $clog2(MAX_DIGITS);
  localparam int COUNT_W  = $clog2(MAX_DIGITS + 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

  localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0] CHAR_A    = CHAR_W'(8'h61);
  localparam logic [CHAR_W-1:0] CHAR_NUL  = '0;

  // digit value 0..35 to '0'..'9', 'a'..'z'
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_W'(10)) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d) - CHAR_W'(10);
    end
    return c;
  endfunction

endpackage

/* sv/itoa_if.sv */
// valid/ready channel interfaces for the converter's input and result streams
interface itoa_in_if import itoa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [IN_VALUE_W-1:0] value;
  logic [RADIX_W-1:0]    radix;

  modport source (output valid, value, radix, input ready);
  modport sink   (input valid, value, radix, output ready);
endinterface

interface itoa_out_if import itoa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last;
  logic              bad_radix;

  modport source (output valid, digit_char, last, bad_radix, input ready);
  modport sink   (input valid, digit_char, last, bad_radix, output ready);
endinterface

/* sv/radix_integer_to_ascii.sv */
// top level: iterative radix integer-to-ascii converter
//
// in_i carries an unsigned value and a radix; a transfer happens on valid
// and ready high at a rising clock edge. out_o gives one ascii digit per
// transfer, most significant first, with last set on the final digit.
// a radix outside 2..36 gives a single NUL result with bad_radix and last.
//
// one shared divide unit makes 8 quotient bits per cycle; each digit takes
// one full pass of division over the value, one byte at a time. readout
// of each digit then reads it from the digit store (the memory read) and
// loads it into the output register.
// the block takes one item at a time; in_i.ready is high only when idle,
// which includes the time the final digit still waits in the output register.
//
// reset clears the sequencer and the output valid; the digit store needs no
// clearing since every entry is written before it is read.
// when the receiver stalls, the output register holds its digit and the
// readout sequencer waits; nothing is lost or repeated.
module radix_integer_to_ascii import itoa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  itoa_in_if.sink     in_i,
  itoa_out_if.source  out_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_OUT  = 3'd3;
  localparam logic [2:0] ST_ERR  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [QUOT_W-1:0]   quot_q, quot_d;
  logic [DIGIT_W-1:0]  rem_q, rem_d;
  logic [RADIX_W-1:0]  radix_q, radix_d;
  logic [CHUNK_W-1:0]  chunk_q, chunk_d;
  logic [COUNT_W-1:0]  count_q, count_d;

  logic                out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]   out_char_q, out_char_d;
  logic                out_last_q, out_last_d;
  logic                out_bad_q, out_bad_d;

  // digit store, remainders least significant first
  logic [DIGIT_W-1:0]  digit_mem [MAX_DIGITS];
  logic                mem_we;
  logic [DIGIT_AW-1:0] mem_waddr;
  logic [DIGIT_W-1:0]  mem_wdata;
  logic [DIGIT_AW-1:0] mem_raddr;
  logic [DIGIT_W-1:0]  mem_rdata_q;

  logic                in_xfer;
  logic                radix_ok;
  logic                out_free;
  logic [QUOT_W-1:0]   step_quot;
  logic [DIGIT_W-1:0]  step_rem;
  logic [COUNT_W-1:0]  count_inc;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign radix_ok   = (in_i.radix >= RADIX_MIN) && (in_i.radix <= RADIX_MAX);
  assign out_free   = !out_valid_q || out_o.ready;
  assign count_inc  = count_q + COUNT_W'(1);

  // shared divide step: shift in the top STEP_BITS of the quotient register
  always_comb begin
    logic [DIGIT_W:0]    r;
    logic [STEP_BITS-1:0] qbits;
    r = {1'b0, rem_q};
    qbits = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      r = {r[DIGIT_W-1:0], quot_q[QUOT_W-1-i]};
      if (r >= {1'b0, radix_q}) begin
        r = r - {1'b0, radix_q};
        qbits[STEP_BITS-1-i] = 1'b1;
      end
    end
    step_rem = r[DIGIT_W-1:0];
    if (QUOT_W > STEP_BITS) begin
      step_quot = {quot_q[QUOT_W-STEP_BITS-1:0], qbits};
    end else begin
      step_quot = QUOT_W'(qbits);
    end
  end

  // readout walks from the highest stored digit down
  assign mem_raddr = DIGIT_AW'(count_q - COUNT_W'(1));

  always_comb begin
    state_d     = state_q;
    quot_d      = quot_q;
    rem_d       = rem_q;
    radix_d     = radix_q;
    chunk_d     = chunk_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_bad_d   = out_bad_q;
    mem_we      = 1'b0;
    mem_waddr   = count_q[DIGIT_AW-1:0];
    mem_wdata   = step_rem;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (radix_ok) begin
            quot_d  = QUOT_W'(in_i.value[VALUE_BITS-1:0]);
            rem_d   = '0;
            radix_d = in_i.radix;
            chunk_d = '0;
            count_d = '0;
            state_d = ST_DIV;
          end else begin
            state_d = ST_ERR;
          end
        end
      end
      ST_DIV: begin
        quot_d  = step_quot;
        rem_d   = step_rem;
        chunk_d = chunk_q + CHUNK_W'(1);
        if (chunk_q == CHUNK_W'(CHUNKS - 1)) begin
          // one full pass over the value: remainder is the next digit
          mem_we  = 1'b1;
          rem_d   = '0;
          chunk_d = '0;
          count_d = count_inc;
          if ((step_quot == '0) || (count_inc == COUNT_W'(MAX_DIGITS))) begin
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = digit_to_ascii(mem_rdata_q);
          out_last_d  = (count_q == COUNT_W'(1));
          out_bad_d   = 1'b0;
          count_d     = count_q - COUNT_W'(1);
          state_d     = (count_q == COUNT_W'(1)) ? ST_IDLE : ST_RD;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_NUL;
          out_last_d  = 1'b1;
          out_bad_d   = 1'b1;
          count_d     = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      chunk_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      chunk_q     <= chunk_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    quot_q     <= quot_d;
    rem_q      <= rem_d;
    radix_q    <= radix_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    out_bad_q  <= out_bad_d;
  end

  // digit store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      digit_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= digit_mem[mem_raddr];
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.digit_char = out_char_q;
  assign out_o.last       = out_last_q;
  assign out_o.bad_radix  = out_bad_q;

endmodule
